FILE: rtl/fbfla_pkg.sv
// Shared types and constants for the fixed-size block free-list allocator.
// No dependencies; the controller, datapath and top level in rtl/ import this package.
package fbfla_pkg;

    // Default pool size and register reset value
    localparam int unsigned MAX_BLOCKS_DEF = 256;
    localparam int unsigned COUNT_W        = 9;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

    // Configuration register indexes
    localparam logic REG_BLOCK_COUNT = 1'b0;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] block;
    } item_t;

    // Result word
    typedef struct packed {
        logic [7:0]         granted_block;
        logic [1:0]         status;
        logic [COUNT_W-1:0] free_count;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the accepted word
        logic exec;        // run allocate, free or no-op
        logic init_write;  // write one link of the init sweep
        logic init_done;   // finish init and report
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;  // effective block count is zero
        logic init_last;   // sweep index is at the last block
    } dp_status_t;

endpackage

FILE: rtl/fbfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfla_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/fbfla_ctrl.sv
// Controller state machine for the block allocator: sequences accept,
// execute and the init sweep. Depends on fbfla_pkg.
module fbfla_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             in_kind,
    input  fbfla_pkg::dp_status_t  status,
    output fbfla_pkg::ctrl_cmd_t   cmd,
    output logic                   busy
);
    import fbfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_INIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_kind == KIND_INIT) ? S_INIT : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                cmd.init_write = !status.count_zero;
                if (status.count_zero || status.init_last)
                begin
                    cmd.init_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // A non-init word runs exactly one execute cycle
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_kind != KIND_INIT) |=> (state_reg == S_EXEC))
        else $error("execute cycle did not follow an accepted word");

    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec && !busy)
        else $error("execute cycle did not return to idle");

    a_init_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_kind == KIND_INIT) |=> (state_reg == S_INIT))
        else $error("init word did not start the sweep");

endmodule

FILE: rtl/fbfla_dp.sv
// Datapath of the block allocator: link memory, head, free counter,
// init sweep index and result register. Depends on fbfla_pkg, fbfla_ram.
module fbfla_dp #(
    parameter int unsigned MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbfla_pkg::item_t              item,
    input  logic [fbfla_pkg::COUNT_W-1:0] block_count,
    input  fbfla_pkg::ctrl_cmd_t          cmd,
    output fbfla_pkg::dp_status_t         status,
    output fbfla_pkg::result_t            result,
    output logic                          done
);
    import fbfla_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_BLOCKS);
    localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CW     = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;
    localparam logic [LINK_W-1:0] NULL_L = LINK_W'(MAX_BLOCKS);

    logic [1:0]        kind_reg;
    logic [7:0]        block_reg;
    logic [LINK_W-1:0] head_reg,  head_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [AW-1:0]     idx_reg,   idx_next;
    result_t           result_reg, result_next;
    logic              done_reg;

    logic [CW-1:0]     bc_wide;
    logic [CW-1:0]     eff_wide;
    logic [LINK_W-1:0] eff_count;
    logic [LINK_W-1:0] idx_plus1;
    logic [LINK_W-1:0] init_link;
    logic [LINK_W-1:0] rd_link;
    logic [LINK_W-1:0] pop_link;
    logic              head_null;
    logic              free_oor;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [LINK_W-1:0] ram_wdata;

    // Clamp the configured count to the pool size
    assign bc_wide   = CW'(block_count);
    assign eff_wide  = (bc_wide > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_wide;
    assign eff_count = LINK_W'(eff_wide);

    assign head_null = (head_reg >= NULL_L);
    assign free_oor  = (CW'(block_reg) >= CW'(eff_count));
    assign idx_plus1 = LINK_W'(idx_reg) + LINK_W'(1);
    assign init_link = status.init_last ? NULL_L : idx_plus1;
    assign pop_link  = (rd_link >= NULL_L) ? NULL_L : rd_link;

    assign status.count_zero = (eff_count == '0);
    assign status.init_last  = (idx_plus1 == eff_count);

    // Link memory: read the head's successor while idle, write on push or sweep
    assign ram_we    = cmd.init_write || (cmd.exec && kind_reg == KIND_FREE && !free_oor);
    assign ram_waddr = cmd.init_write ? idx_reg : AW'(block_reg);
    assign ram_wdata = cmd.init_write ? init_link : head_reg;

    fbfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(head_reg)),
        .rdata (rd_link)
    );

    // Operation decode: pop, push, sweep and result
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        if (cmd.init_write)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.exec)
        begin
            result_next.granted_block = '0;
            result_next.status        = ST_OK;
            case (kind_reg)
                KIND_ALLOC:
                begin
                    if (head_null)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.granted_block = 8'(head_reg);
                        head_next  = pop_link;
                        count_next = (count_reg == '0) ? count_reg
                                                       : count_reg - LINK_W'(1);
                    end
                end
                KIND_FREE:
                begin
                    if (free_oor)
                    begin
                        result_next.status = ST_RANGE;
                    end
                    else
                    begin
                        head_next  = LINK_W'(block_reg);
                        count_next = (count_reg >= NULL_L) ? count_reg
                                                           : count_reg + LINK_W'(1);
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
            result_next.free_count = COUNT_W'(count_next);
        end
        if (cmd.init_done)
        begin
            head_next  = status.count_zero ? NULL_L : '0;
            count_next = eff_count;
            result_next.granted_block = '0;
            result_next.status        = ST_OK;
            result_next.free_count    = COUNT_W'(eff_count);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NULL_L;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= cmd.exec || cmd.init_done;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= item.kind;
            block_reg <= item.block;
        end
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_L)
        else $error("list head beyond the null link");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL_L)
        else $error("free count beyond the pool size");

    a_empty_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != ST_OK) |-> (result_reg.granted_block == '0))
        else $error("failed operation reported a granted block");

endmodule

FILE: rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-size block free-list allocator: APB register,
// controller and datapath. Depends on fbfla_pkg, fbfla_ctrl, fbfla_dp.
//
//  Channel   Signals                           Handshake
//  --------  --------------------------------  ---------------------------------
//  command   start, busy, item                 word taken when start && !busy
//  result    done, result                      one-cycle strobe, no backpressure
//  config    psel penable pwrite paddr pwdata  APB, written on access phase
//            prdata pready                     pready tied high
//
// Allocate, free and unused kinds pass through the accept and then the
// execute state that uses the link read issued from the head while idle.
// Init writes one link per cycle over the clamped block count n on the single
// RAM write port. The result strobe comes the cycle after the last busy cycle;
// a new word may be taken in that same cycle.
// Reset empties the list (null head, count zero) and sets block_count to 256;
// the link memory needs no clearing pass. The receiver cannot stall results.
module fixed_block_free_list_allocator #(
    parameter int unsigned MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fbfla_pkg::item_t   item,
    output logic               done,
    output fbfla_pkg::result_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fbfla_pkg::*;

    logic [COUNT_W-1:0] block_count_reg;
    logic               reg_index;
    logic               cfg_write;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    // APB register decode
    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_BLOCK_COUNT) ? 32'(block_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_write && reg_index == REG_BLOCK_COUNT)
        begin
            block_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    fbfla_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_kind (item.kind),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    fbfla_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .block_count (block_count_reg),
        .cmd         (cmd),
        .status      (status),
        .result      (result),
        .done        (done)
    );

endmodule

FILE: dv/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for the fixed-size block free-list allocator.
// Depends on fbfla_pkg and fixed_block_free_list_allocator from rtl/.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;

    import fbfla_pkg::*;

    localparam logic [1:0]         KIND_UNUSED  = 2'd3;
    localparam logic [COUNT_W-1:0] POOL_MAX     = COUNT_W'(MAX_BLOCKS_DEF);
    localparam logic [COUNT_W-1:0] LINK_NULL    = COUNT_W'(MAX_BLOCKS_DEF);
    localparam logic [2:0]         ADDR_COUNT   = {REG_BLOCK_COUNT, 2'b00};
    localparam int                 LIMIT_CYCLES = 300000;
    localparam int                 RAND_PHASES  = 8;
    localparam int                 PHASE_ITEMS  = 135;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       cmd_word;
    logic        done;
    result_t     res_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the pool: link memory, head, free counter and register
    logic [COUNT_W-1:0] link_shadow [MAX_BLOCKS_DEF];
    logic [COUNT_W-1:0] head_shadow;
    logic [COUNT_W-1:0] total_shadow;
    logic [COUNT_W-1:0] count_shadow;

    result_t    reply_q [$];
    logic [7:0] held_q [$];
    int         err_count;
    int         cycles;
    int         burst_left;

    fixed_block_free_list_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (cmd_word),
        .done    (done),
        .result  (res_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("fixed_block_free_list_allocator_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("[%0t] ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    // Apply one word to the shadow pool and return the reply it produces
    task automatic pool_apply(input item_t w, output result_t r);
        logic [COUNT_W-1:0] lim;
        logic [COUNT_W-1:0] nxt;
        r.granted_block = '0;
        r.status        = ST_OK;
        lim = (count_shadow > POOL_MAX) ? POOL_MAX : count_shadow;
        case (w.kind)
            KIND_ALLOC:
            begin
                if (head_shadow >= LINK_NULL)
                    r.status = ST_EMPTY;
                else
                begin
                    nxt             = link_shadow[head_shadow[7:0]];
                    r.granted_block = head_shadow[7:0];
                    head_shadow     = (nxt >= LINK_NULL) ? LINK_NULL : nxt;
                    if (total_shadow > 0)
                        total_shadow = total_shadow - 1'b1;
                end
            end
            KIND_FREE:
            begin
                if ({1'b0, w.block} >= lim)
                    r.status = ST_RANGE;
                else
                begin
                    link_shadow[w.block] = head_shadow;
                    head_shadow          = {1'b0, w.block};
                    if (total_shadow < POOL_MAX)
                        total_shadow = total_shadow + 1'b1;
                end
            end
            KIND_INIT:
            begin
                for (int i = 0; i < lim; i++)
                    link_shadow[i] = (i + 1 < lim) ? COUNT_W'(i + 1) : LINK_NULL;
                head_shadow  = (lim > 0) ? '0 : LINK_NULL;
                total_shadow = lim;
            end
            default: ;
        endcase
        r.free_count = total_shadow;
    endtask

    // Offer one word until taken, then queue its predicted reply
    task automatic send_word(input logic [1:0] k, input logic [7:0] b,
                             output result_t predicted);
        item_t w;
        logic  was_busy;
        w.kind  = k;
        w.block = b;
        start    <= 1'b1;
        cmd_word <= w;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end while (was_busy);
        pool_apply(w, predicted);
        reply_q.push_back(predicted);
    endtask

    task automatic issue(input logic [1:0] k, input logic [7:0] b);
        result_t unused_reply;
        send_word(k, b, unused_reply);
    endtask

    // Drop start for a pause set by n, with junk on the command bus
    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start    <= 1'b0;
            cmd_word <= item_t'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold the sender until every reply is back and the block is idle
    task automatic wait_drain();
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Optionally write block_count, then read it back and compare
    task automatic access_block_count(input bit do_write, input logic [8:0] value);
        logic        rdy;
        logic [31:0] rd;
        if (do_write)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_COUNT;
            pwdata  <= {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, value};
            @(posedge clk);
            penable <= 1'b1;
            do
            begin
                @(negedge clk);
                rdy = pready;
                @(posedge clk);
            end while (!rdy);
            count_shadow = value;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            rd  = prdata;
            @(posedge clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd[8:0] !== count_shadow)
            report_mismatch($sformatf("block_count read %0d, want %0d", rd[8:0],
                                      count_shadow));
    endtask

    // Check each reply strobe against the oldest prediction
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
                report_mismatch("reply word with no outstanding command");
            else
            begin
                want = reply_q.pop_front();
                if (res_word.granted_block !== want.granted_block)
                    report_mismatch($sformatf("granted_block %0d, want %0d",
                                              res_word.granted_block, want.granted_block));
                if (res_word.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              res_word.status, want.status));
                if (res_word.free_count !== want.free_count)
                    report_mismatch($sformatf("free_count %0d, want %0d",
                                              res_word.free_count, want.free_count));
            end
        end
    end

    // Reset value of the register, and allocate, unused and free words before init
    task automatic test_power_up();
        access_block_count(1'b0, '0);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_UNUSED, 8'd255);
        issue(KIND_FREE, 8'd255);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_ALLOC, 8'd17);
        wait_drain();
    endtask

    // Full pool: pops, pushes, double free and counter saturation at the top
    task automatic test_basic_ops();
        issue(KIND_INIT, 8'd255);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_ALLOC, 8'd255);
        issue(KIND_FREE, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_FREE, 8'd255);
        issue(KIND_FREE, 8'd7);
        issue(KIND_FREE, 8'd9);
        issue(KIND_UNUSED, 8'd0);
        wait_drain();
    endtask

    // Register extremes: one block, zero blocks, oversize counts
    task automatic test_count_extremes();
        access_block_count(1'b1, 9'd1);
        issue(KIND_INIT, 8'd0);
        issue(KIND_FREE, 8'd1);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        // double free builds a cycle; the counter floors at zero
        issue(KIND_FREE, 8'd0);
        issue(KIND_FREE, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        wait_drain();
        access_block_count(1'b1, 9'd0);
        issue(KIND_INIT, 8'd0);
        issue(KIND_FREE, 8'd0);
        issue(KIND_ALLOC, 8'd0);
        wait_drain();
        access_block_count(1'b1, 9'd511);
        issue(KIND_INIT, 8'd0);
        issue(KIND_FREE, 8'd255);
        wait_drain();
        access_block_count(1'b1, 9'd257);
    endtask

    // Mostly well-formed alloc/free traffic on a fresh pool, plus noise
    task automatic test_random_traffic();
        logic [8:0]         phase_count [RAND_PHASES];
        logic [COUNT_W-1:0] lim;
        result_t            reply;
        logic [1:0]         k;
        logic [7:0]         b;
        int                 pick;
        int                 j;
        phase_count = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd1, 9'd257,
                        9'($urandom_range(3, 255)), 9'($urandom_range(3, 255))};
        burst_left = 0;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_drain();
            access_block_count(1'b1, phase_count[p]);
            held_q.delete();
            issue(KIND_INIT, 8'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pace the sender in bursts, sometimes letting it run dry
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 40) == 0)
                        wait_drain();
                    else
                        hold_off($urandom_range(1, 7));
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 10);
                end
                burst_left--;
                lim  = (count_shadow > POOL_MAX) ? POOL_MAX : count_shadow;
                pick = $urandom_range(0, 99);
                b    = 8'($urandom);
                if (pick < 45)
                    k = KIND_ALLOC;
                else if (pick < 80)
                begin
                    if (held_q.size() != 0)
                    begin
                        j = $urandom_range(0, held_q.size() - 1);
                        b = held_q[j];
                        held_q.delete(j);
                        k = KIND_FREE;
                    end
                    else
                        k = KIND_ALLOC;
                end
                else if (pick < 88)
                    k = KIND_FREE;
                else if (pick < 93)
                    k = KIND_UNUSED;
                else if (pick < 96)
                    k = KIND_INIT;
                else
                begin
                    // free right at the edge of the pool
                    k = KIND_FREE;
                    b = 8'(lim - $urandom_range(0, 1));
                end
                send_word(k, b, reply);
                if (k == KIND_INIT)
                    held_q.delete();
                else if (k == KIND_ALLOC && reply.status == ST_OK)
                    held_q.push_back(reply.granted_block);
            end
        end
    endtask

    initial
    begin
        int spin;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd_word  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        err_count = 0;
        cycles    = 0;
        // shadow matches the reset state of the block
        head_shadow  = LINK_NULL;
        total_shadow = '0;
        count_shadow = BLOCK_COUNT_RST;
        foreach (link_shadow[i])
            link_shadow[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_basic_ops();
        test_count_extremes();
        test_random_traffic();

        // let the last replies land, bounded by the longest init
        start <= 1'b0;
        spin = 0;
        while (reply_q.size() != 0 && spin < 2000)
        begin
            @(posedge clk);
            spin++;
        end
        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("fixed_block_free_list_allocator_tb: PASS");
        else
            $display("fixed_block_free_list_allocator_tb: FAIL");
        $finish;
    end

endmodule
